/* sv/caldate_pkg.sv */
`timescale 1ns / 1ps
package caldate_pkg;

  localparam int YEAR_BITS = 16;

  // Multiplicative inverse of 25 modulo 2^32 for the divisibility test
  localparam logic [31:0] INV25 = 32'hC28F5C29;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_NEXT    = 2'd1;
  localparam logic [1:0] REQ_PREV    = 2'd2;
  localparam logic [1:0] REQ_COMPARE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MONTH = 2'd1;
  localparam logic [1:0] ST_BAD_DAY   = 2'd2;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef logic [YEAR_BITS-1:0] year_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [15:0] year_in;
  } caldate_in_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        is_before;
    logic        is_same;
    logic [1:0]  status;
  } caldate_out_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    year_t      year;
  } date_t;

  typedef struct packed {
    date_t      date;
    logic       earlier;
    logic       same;
    logic [1:0] status;
  } caldate_res_t;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/caldate_leap.sv */
`timescale 1ns / 1ps
module caldate_leap import caldate_pkg::*; (
  input  year_t year,
  output logic  leap
);

  localparam logic [YEAR_BITS-1:0] DIV25_MAX =
    YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / 64'd25);

  logic [YEAR_BITS-1:0] prod;
  logic                 div4;
  logic                 div16;
  logic                 div25;

  // y is a multiple of 25 exactly when y * inv(25) mod 2^n stays within (2^n - 1) / 25
  assign prod  = year * INV25[YEAR_BITS-1:0];
  assign div25 = prod <= DIV25_MAX;
  assign div4  = year[1:0] == 2'd0;
  assign div16 = year[3:0] == 4'd0;
  assign leap  = div4 && (!div25 || div16);

endmodule

/* sv/caldate_core.sv */
`timescale 1ns / 1ps
module caldate_core import caldate_pkg::*; (
  input  caldate_in_t  req,
  input  date_t        cur,
  output caldate_res_t res
);

  year_t      y_in;
  logic       leap_cur;
  logic       leap_in;
  logic [4:0] dim_cur;
  logic [4:0] dim_prev;
  logic [4:0] dim_load;
  logic       month_ok;
  logic [3:0] month_load;
  logic [3:0] month_prev;
  logic       day_ok;

  assign y_in = YEAR_BITS'(req.year_in);

  caldate_leap u_leap_cur (
    .year (cur.year),
    .leap (leap_cur)
  );

  caldate_leap u_leap_in (
    .year (y_in),
    .leap (leap_in)
  );

  assign month_ok   = (req.month_in >= MONTH_JAN) && (req.month_in <= MONTH_DEC);
  assign month_load = month_ok ? req.month_in : MONTH_JAN;
  assign dim_load   = days_in(month_load, leap_in);
  assign day_ok     = (req.day_in != 5'd0) && (req.day_in <= dim_load);
  assign dim_cur    = days_in(cur.month, leap_cur);
  assign month_prev = cur.month - 4'd1;
  assign dim_prev   = days_in(month_prev, leap_cur);

  always_comb begin
    res.date    = cur;
    res.earlier = 1'b0;
    res.same    = 1'b0;
    res.status  = ST_OK;
    case (req.req_type)
      REQ_LOAD: begin
        res.date.year  = y_in;
        res.date.month = month_load;
        res.date.day   = day_ok ? req.day_in : 5'd1;
        if (!month_ok) begin
          res.status = ST_BAD_MONTH;
        end else if (!day_ok) begin
          res.status = ST_BAD_DAY;
        end
      end
      REQ_NEXT: begin
        if (cur.day < dim_cur) begin
          res.date.day = cur.day + 5'd1;
        end else begin
          res.date.day = 5'd1;
          if (cur.month < MONTH_DEC) begin
            res.date.month = cur.month + 4'd1;
          end else begin
            res.date.month = MONTH_JAN;
            res.date.year  = cur.year + year_t'(1);
          end
        end
      end
      REQ_PREV: begin
        if (cur.day > 5'd1) begin
          res.date.day = cur.day - 5'd1;
        end else if (cur.month > MONTH_JAN) begin
          res.date.month = month_prev;
          res.date.day   = dim_prev;
        end else begin
          res.date.month = MONTH_DEC;
          res.date.year  = cur.year - year_t'(1);
          res.date.day   = days_in(MONTH_DEC, 1'b0);
        end
      end
      REQ_COMPARE: begin
        if (cur.year != y_in) begin
          res.earlier = cur.year < y_in;
        end else if (cur.month != req.month_in) begin
          res.earlier = cur.month < req.month_in;
        end else if (cur.day != req.day_in) begin
          res.earlier = cur.day < req.day_in;
        end else begin
          res.same = 1'b1;
        end
      end
      default: begin
        res.date = cur;
      end
    endcase
  end

endmodule

/* sv/calendar_date_counter_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     caldate_in_t  (request, day, month, year)
// out_      output     out_valid / out_stall   caldate_out_t (date, compare flags, status)
//
// One transaction per cycle sustained while out_stall is low; a request passes the input
// register then the result register, with the date update done in the logic between them.
// Reset sets the date to 1 January of year 1 and empties both registers.
// out_stall holds the result register; the input register then fills and
// in_stall rises until the result is taken.
module calendar_date_counter_top import caldate_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  caldate_in_t  in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output caldate_out_t out_data
);

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  caldate_in_t  s1_data_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  caldate_out_t out_data_r;
  caldate_out_t out_data_nxt;
  date_t        cur_r;
  date_t        cur_nxt;
  caldate_res_t res;
  logic         out_free;
  logic         adv;
  logic         in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  caldate_core u_core (
    .req (s1_data_r),
    .cur (cur_r),
    .res (res)
  );

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && out_stall);
    cur_nxt       = adv ? res.date : cur_r;
    out_data_nxt.day_out   = res.date.day;
    out_data_nxt.month_out = res.date.month;
    out_data_nxt.year_out  = 16'(res.date.year);
    out_data_nxt.is_before = res.earlier;
    out_data_nxt.is_same   = res.same;
    out_data_nxt.status    = res.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_r.day   <= 5'd1;
      cur_r.month <= MONTH_JAN;
      cur_r.year  <= year_t'(1);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.month >= MONTH_JAN) && (cur_r.month <= MONTH_DEC))
    else $error("stored month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.day != 5'd0) && (cur_r.day <= days_in(cur_r.month, 1'b1)))
    else $error("stored day out of range");

  a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.is_before && out_data_r.is_same))
    else $error("compare flags both set");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && (out_data_r.day_out == cur_r.day))
    else $error("advanced transaction did not reach result register");

endmodule

/* verif/calendar_date_counter_top_test.sv */
`timescale 1ns / 1ps
module calendar_date_counter_top_test;
  import caldate_pkg::*;

  typedef struct {
    caldate_in_t  req;
    bit           typed;
    caldate_out_t want;
  } directed_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  caldate_in_t  in_data;
  logic         out_valid;
  logic         out_stall = 1'b0;
  caldate_out_t out_data;

  logic [4:0] cal_day;
  logic [3:0] cal_month;
  year_t      cal_year;

  caldate_out_t  pending_dates[$];
  directed_row_t directed_tab[$];
  bit            quiet;
  int            mismatches;
  int            results_seen;
  int            rejected_loads;
  int            equal_compares;
  int            boundary_steps;

  calendar_date_counter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [4:0] month_length(input logic [3:0] m, input year_t y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    case (m)
      MONTH_FEB: return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic caldate_out_t advance_calendar(input caldate_in_t r);
    caldate_out_t res;
    year_t        y;
    res = '0;
    y = year_t'(r.year_in);
    case (r.req_type)
      REQ_LOAD: begin
        cal_year = y;
        if (r.month_in < MONTH_JAN || r.month_in > MONTH_DEC) begin
          cal_month = MONTH_JAN;
          res.status = ST_BAD_MONTH;
        end else begin
          cal_month = r.month_in;
        end
        if (r.day_in == 0 || r.day_in > month_length(cal_month, cal_year)) begin
          cal_day = 1;
          if (res.status == ST_OK) res.status = ST_BAD_DAY;
        end else begin
          cal_day = r.day_in;
        end
        if (res.status != ST_OK) rejected_loads++;
      end
      REQ_NEXT: begin
        if (cal_day < month_length(cal_month, cal_year)) begin
          cal_day++;
        end else begin
          boundary_steps++;
          cal_day = 1;
          if (cal_month < MONTH_DEC) begin
            cal_month++;
          end else begin
            cal_month = MONTH_JAN;
            cal_year++;
          end
        end
      end
      REQ_PREV: begin
        if (cal_day > 1) begin
          cal_day--;
        end else begin
          boundary_steps++;
          if (cal_month > MONTH_JAN) begin
            cal_month--;
          end else begin
            cal_month = MONTH_DEC;
            cal_year--;
          end
          cal_day = month_length(cal_month, cal_year);
        end
      end
      REQ_COMPARE: begin
        if (cal_year != y) res.is_before = (cal_year < y);
        else if (cal_month != r.month_in) res.is_before = (cal_month < r.month_in);
        else if (cal_day != r.day_in) res.is_before = (cal_day < r.day_in);
        else res.is_same = 1'b1;
        if (res.is_same) equal_compares++;
      end
      default: ;
    endcase
    res.day_out = cal_day;
    res.month_out = cal_month;
    res.year_out = 16'(cal_year);
    return res;
  endfunction

  function automatic directed_row_t plain_row(input logic [1:0] kind, input int d, input int m,
                                              input int y);
    directed_row_t row;
    row.req = '{req_type: kind, day_in: 5'(d), month_in: 4'(m), year_in: 16'(y)};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic directed_row_t typed_row(input logic [1:0] kind, input int d, input int m,
                                              input int y, input int ed, input int em,
                                              input int ey, input bit eb, input bit es,
                                              input logic [1:0] est);
    directed_row_t row;
    row = plain_row(kind, d, m, y);
    row.typed = 1'b1;
    row.want = '{day_out: 5'(ed), month_out: 4'(em), year_out: 16'(ey),
                 is_before: eb, is_same: es, status: est};
    return row;
  endfunction

  function automatic logic [15:0] pick_year();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'(400 * $urandom_range(0, 163));
      3: return 16'(100 * $urandom_range(0, 655));
      4: return 16'(4 * $urandom_range(0, 16383));
      5: return 16'd1;
      6: return 16'(16'hFFFF - $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic caldate_in_t random_request();
    caldate_in_t r;
    int          pick;
    logic [4:0]  len;
    r.req_type = REQ_NEXT;
    r.day_in = 5'($urandom);
    r.month_in = 4'($urandom);
    r.year_in = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      r.req_type = REQ_LOAD;
      if ($urandom_range(9) < 7) begin
        r.year_in = pick_year();
        r.month_in = 4'($urandom_range(1, 12));
        len = month_length(r.month_in, year_t'(r.year_in));
        case ($urandom_range(3))
          0: r.day_in = 5'd1;
          1: r.day_in = len;
          2: r.day_in = len - 5'd1;
          default: r.day_in = 5'($urandom_range(1, len));
        endcase
      end
    end else if (pick < 55) begin
      r.req_type = REQ_NEXT;
    end else if (pick < 85) begin
      r.req_type = REQ_PREV;
    end else begin
      r.req_type = REQ_COMPARE;
      if ($urandom_range(1)) begin
        r.day_in = cal_day;
        r.month_in = cal_month;
        r.year_in = 16'(cal_year);
        case ($urandom_range(3))
          0: r.day_in = cal_day + 5'($urandom_range(0, 2)) - 5'd1;
          1: r.month_in = cal_month + 4'($urandom_range(0, 2)) - 4'd1;
          2: r.year_in = 16'(cal_year) + 16'($urandom_range(0, 2)) - 16'd1;
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(input caldate_in_t r, input bit typed, input caldate_out_t want);
    caldate_out_t predicted;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    predicted = advance_calendar(r);
    pending_dates.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (pending_dates.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  always @(negedge clk) begin
    out_stall <= (!quiet && $urandom_range(99) < 17);
  end

  always @(posedge clk) begin : watch_results
    caldate_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, day", out_data.day_out, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_data.day_out !== want.day_out)
          report_mismatch("day_out", out_data.day_out, want.day_out);
        if (out_data.month_out !== want.month_out)
          report_mismatch("month_out", out_data.month_out, want.month_out);
        if (out_data.year_out !== want.year_out)
          report_mismatch("year_out", out_data.year_out, want.year_out);
        if (out_data.is_before !== want.is_before)
          report_mismatch("is_before", out_data.is_before, want.is_before);
        if (out_data.is_same !== want.is_same)
          report_mismatch("is_same", out_data.is_same, want.is_same);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    cal_day = 5'd1;
    cal_month = MONTH_JAN;
    cal_year = year_t'(1);

    directed_tab.push_back(typed_row(REQ_NEXT, 0, 0, 0, 2, 1, 1, 0, 0, ST_OK));
    directed_tab.push_back(typed_row(REQ_PREV, 31, 15, 65535, 1, 1, 1, 0, 0, ST_OK));
    directed_tab.push_back(typed_row(REQ_PREV, 0, 0, 0, 31, 12, 0, 0, 0, ST_OK));
    directed_tab.push_back(typed_row(REQ_COMPARE, 31, 12, 0, 31, 12, 0, 0, 1, ST_OK));
    directed_tab.push_back(plain_row(REQ_NEXT, 17, 9, 1234));
    directed_tab.push_back(typed_row(REQ_LOAD, 31, 12, 65535, 31, 12, 65535, 0, 0, ST_OK));
    directed_tab.push_back(typed_row(REQ_NEXT, 0, 0, 0, 1, 1, 0, 0, 0, ST_OK));
    directed_tab.push_back(typed_row(REQ_PREV, 0, 0, 0, 31, 12, 65535, 0, 0, ST_OK));
    directed_tab.push_back(typed_row(REQ_LOAD, 5, 0, 2000, 5, 1, 2000, 0, 0, ST_BAD_MONTH));
    directed_tab.push_back(typed_row(REQ_LOAD, 0, 13, 1999, 1, 1, 1999, 0, 0, ST_BAD_MONTH));
    directed_tab.push_back(typed_row(REQ_LOAD, 31, 15, 2024, 31, 1, 2024, 0, 0, ST_BAD_MONTH));
    directed_tab.push_back(typed_row(REQ_LOAD, 0, 6, 2023, 1, 6, 2023, 0, 0, ST_BAD_DAY));
    directed_tab.push_back(typed_row(REQ_LOAD, 31, 4, 2023, 1, 4, 2023, 0, 0, ST_BAD_DAY));
    directed_tab.push_back(typed_row(REQ_LOAD, 29, 2, 2024, 29, 2, 2024, 0, 0, ST_OK));
    directed_tab.push_back(plain_row(REQ_NEXT, 0, 0, 0));
    directed_tab.push_back(plain_row(REQ_PREV, 0, 0, 0));
    directed_tab.push_back(typed_row(REQ_LOAD, 29, 2, 1900, 1, 2, 1900, 0, 0, ST_BAD_DAY));
    directed_tab.push_back(plain_row(REQ_LOAD, 28, 2, 2100));
    directed_tab.push_back(plain_row(REQ_NEXT, 0, 0, 0));
    directed_tab.push_back(plain_row(REQ_LOAD, 1, 3, 2000));
    directed_tab.push_back(plain_row(REQ_PREV, 0, 0, 0));
    directed_tab.push_back(plain_row(REQ_COMPARE, 29, 2, 2000));
    directed_tab.push_back(plain_row(REQ_COMPARE, 1, 1, 2001));
    directed_tab.push_back(plain_row(REQ_COMPARE, 31, 1, 2000));
    directed_tab.push_back(plain_row(REQ_COMPARE, 0, 15, 2000));
    directed_tab.push_back(typed_row(REQ_LOAD, 29, 2, 0, 29, 2, 0, 0, 0, ST_OK));
    directed_tab.push_back(plain_row(REQ_COMPARE, 31, 15, 65535));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_tab[i])
      send_request(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].want);

    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();

    for (int n = 0; n < 850; n++) begin
      quiet = (n >= 300 && n < 450);
      if (n == 600) begin
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
      end
      send_request(random_request(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    while (pending_dates.size() != 0) begin
      void'(pending_dates.pop_front());
      report_mismatch("missing result, outstanding", pending_dates.size() + 1, 0);
    end

    $display("Covered %0d results from %0d directed and 850 random transactions",
             results_seen, directed_tab.size());
    $display("%0d loads repaired, %0d equal compares, %0d month or year crossings",
             rejected_loads, equal_compares, boundary_steps);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/caldate_pkg.sv
sv/caldate_leap.sv
sv/caldate_core.sv
sv/calendar_date_counter_top.sv
verif/calendar_date_counter_top_test.sv
